// ----- hw/rtl/tdr_pkg.sv -----
// tdr_pkg: shared sizes, register indexes and types for the dihedral remap block
// no dependencies; imported by every module of the block
package tdr_pkg;

    localparam int MAX_SIDE     = 32;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_BATCH    = 256;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 24;

    localparam int SIDE_W  = $clog2(MAX_SIDE);
    localparam int CHAN_W  = $clog2(MAX_CHANNELS);
    localparam int BATCH_W = $clog2(MAX_BATCH);

    localparam int STRIDE_W = $clog2(MAX_SIDE * MAX_CHANNELS + 1);
    localparam int CSTR_W   = $clog2(MAX_CHANNELS + 1);

    localparam int BATCH_REG_W = 9;
    localparam int SIDE_REG_W  = 6;
    localparam int CHAN_REG_W  = 7;
    localparam int SYM_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [BATCH_REG_W-1:0] RST_BATCH    = BATCH_REG_W'(1);
    localparam logic [SIDE_REG_W-1:0]  RST_HEIGHT   = SIDE_REG_W'(19);
    localparam logic [SIDE_REG_W-1:0]  RST_WIDTH    = SIDE_REG_W'(19);
    localparam logic [CHAN_REG_W-1:0]  RST_CHANNELS = CHAN_REG_W'(1);

    localparam int SYM_FLIP_ROWS = 0;
    localparam int SYM_FLIP_COLS = 1;
    localparam int SYM_TRANSPOSE = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATCH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_CHANNELS = 3'd3,
        CFG_LAYOUT   = 3'd4,
        CFG_SYMMETRY = 3'd5,
        CFG_REVERSE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [BATCH_W-1:0]  nb_m1;
        logic [SIDE_W-1:0]   nh_m1;
        logic [SIDE_W-1:0]   nw_m1;
        logic [CHAN_W-1:0]   nc_m1;
        logic                nhwc;
        logic                transpose;
        logic                flip_x;
        logic                flip_y;
        logic [STRIDE_W-1:0] row_stride;
        logic [CSTR_W-1:0]   col_stride;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SIDE_W-1:0]  dr;
        logic [SIDE_W-1:0]  dc;
        logic [CHAN_W-1:0]  chan;
        logic [INDEX_W-1:0] base;
        logic               last;
    } t_item;

endpackage

// ----- hw/rtl/tdr_cfg.sv -----
// tdr_cfg: configuration registers, size clamping and derived strides
// depends on tdr_pkg
module tdr_cfg import tdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_restart
);

    logic [BATCH_REG_W-1:0] r_batch;
    logic [SIDE_REG_W-1:0]  r_height;
    logic [SIDE_REG_W-1:0]  r_width;
    logic [CHAN_REG_W-1:0]  r_channels;
    logic                   r_nhwc;
    logic [SYM_W-1:0]       r_sym;
    logic                   r_reverse;
    logic [STRIDE_W-1:0]    r_row_stride;
    logic [STRIDE_W-1:0]    n_row_stride;

    logic                   transpose;
    logic [SIDE_W:0]        nw_eff;
    logic [CHAN_W:0]        nc_eff;
    logic [SIDE_W+CHAN_W+1:0] wc_prod;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_REG_W-1:0] raw);
        logic [SIDE_W-1:0] res;
        if (raw == '0) begin
            res = '0;
        end else if (int'(raw) > MAX_SIDE) begin
            res = SIDE_W'(MAX_SIDE - 1);
        end else begin
            res = SIDE_W'(raw - 1'b1);
        end
        return res;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_REG_W-1:0] raw);
        logic [CHAN_W-1:0] res;
        if (raw == '0) begin
            res = '0;
        end else if (int'(raw) > MAX_CHANNELS) begin
            res = CHAN_W'(MAX_CHANNELS - 1);
        end else begin
            res = CHAN_W'(raw - 1'b1);
        end
        return res;
    endfunction

    function automatic logic [BATCH_W-1:0] clamp_batch(input logic [BATCH_REG_W-1:0] raw);
        logic [BATCH_W-1:0] res;
        if (raw == '0) begin
            res = '0;
        end else if (int'(raw) > MAX_BATCH) begin
            res = BATCH_W'(MAX_BATCH - 1);
        end else begin
            res = BATCH_W'(raw - 1'b1);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch    <= RST_BATCH;
            r_height   <= RST_HEIGHT;
            r_width    <= RST_WIDTH;
            r_channels <= RST_CHANNELS;
            r_nhwc     <= 1'b0;
            r_sym      <= '0;
            r_reverse  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BATCH:    r_batch    <= i_cfg_data[BATCH_REG_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIDE_REG_W-1:0];
                CFG_WIDTH:    r_width    <= i_cfg_data[SIDE_REG_W-1:0];
                CFG_CHANNELS: r_channels <= i_cfg_data[CHAN_REG_W-1:0];
                CFG_LAYOUT:   r_nhwc     <= i_cfg_data[0];
                CFG_SYMMETRY: r_sym      <= i_cfg_data[SYM_W-1:0];
                CFG_REVERSE:  r_reverse  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // row stride feeds the result stage only, through one more register after the config registers
    always_ff @(posedge i_clk) begin
        r_row_stride <= n_row_stride;
    end

    always_comb begin
        o_restart = 1'b0;
        case (t_cfg_idx'(i_cfg_index))
            CFG_BATCH, CFG_HEIGHT, CFG_WIDTH, CFG_CHANNELS,
            CFG_LAYOUT, CFG_SYMMETRY, CFG_REVERSE: o_restart = i_cfg_we;
            default: o_restart = 1'b0;
        endcase
    end

    always_comb begin
        o_cfg.nb_m1 = clamp_batch(r_batch);
        o_cfg.nh_m1 = clamp_side(r_height);
        o_cfg.nw_m1 = clamp_side(r_width);
        o_cfg.nc_m1 = clamp_chan(r_channels);
        o_cfg.nhwc  = r_nhwc;

        transpose = r_sym[SYM_TRANSPOSE] && (o_cfg.nh_m1 == o_cfg.nw_m1);
        o_cfg.transpose = transpose;
        // forward transpose swaps the roles of the two flips
        if (transpose && !r_reverse) begin
            o_cfg.flip_x = r_sym[SYM_FLIP_ROWS];
            o_cfg.flip_y = r_sym[SYM_FLIP_COLS];
        end else begin
            o_cfg.flip_x = r_sym[SYM_FLIP_COLS];
            o_cfg.flip_y = r_sym[SYM_FLIP_ROWS];
        end

        nw_eff  = {1'b0, o_cfg.nw_m1} + 1'b1;
        nc_eff  = {1'b0, o_cfg.nc_m1} + 1'b1;
        wc_prod = nw_eff * nc_eff;
        if (r_nhwc) begin
            n_row_stride     = wc_prod[STRIDE_W-1:0];
            o_cfg.col_stride = CSTR_W'(nc_eff);
        end else begin
            n_row_stride     = STRIDE_W'(nw_eff);
            o_cfg.col_stride = CSTR_W'(1);
        end
        o_cfg.row_stride = r_row_stride;
    end

endmodule

// ----- hw/rtl/tdr_seq.sv -----
// tdr_seq: source order counters, plane base tracking and input register stage
// depends on tdr_pkg
module tdr_seq import tdr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_restart,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_s1_vld,
    input  logic               i_s1_ready,
    output t_item              o_s1
);

    logic [BATCH_W-1:0] r_batch, n_batch;
    logic [SIDE_W-1:0]  r_row, n_row;
    logic [SIDE_W-1:0]  r_col, n_col;
    logic [CHAN_W-1:0]  r_chan, n_chan;
    logic [INDEX_W-1:0] r_src, n_src;
    logic [INDEX_W-1:0] r_base, n_base;
    logic               r_s1_vld;
    t_item              r_s1, n_s1;

    logic accept, end_chan, end_col, end_row, end_batch, plane_end, last;

    assign o_in_ready = !r_s1_vld || i_s1_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_s1_vld   = r_s1_vld;
    assign o_s1       = r_s1;

    always_comb begin
        end_chan  = (r_chan == i_cfg.nc_m1);
        end_col   = (r_col == i_cfg.nw_m1);
        end_row   = (r_row == i_cfg.nh_m1);
        end_batch = (r_batch == i_cfg.nb_m1);
        if (i_cfg.nhwc) begin
            plane_end = end_chan && end_col && end_row;
            last      = plane_end && end_batch;
        end else begin
            plane_end = end_col && end_row;
            last      = plane_end && end_chan && end_batch;
        end

        n_batch = r_batch;
        n_row   = r_row;
        n_col   = r_col;
        n_chan  = r_chan;
        if (i_cfg.nhwc) begin
            n_chan = end_chan ? '0 : r_chan + 1'b1;
            if (end_chan) begin
                n_col = end_col ? '0 : r_col + 1'b1;
            end
            if (end_chan && end_col) begin
                n_row = end_row ? '0 : r_row + 1'b1;
            end
            if (plane_end) begin
                n_batch = end_batch ? '0 : r_batch + 1'b1;
            end
        end else begin
            // planes run channel within batch
            n_col = end_col ? '0 : r_col + 1'b1;
            if (end_col) begin
                n_row = end_row ? '0 : r_row + 1'b1;
            end
            if (plane_end) begin
                n_chan = end_chan ? '0 : r_chan + 1'b1;
            end
            if (plane_end && end_chan) begin
                n_batch = end_batch ? '0 : r_batch + 1'b1;
            end
        end
        n_src  = last ? '0 : r_src + 1'b1;
        n_base = plane_end ? n_src : r_base;

        n_s1.value = i_value;
        n_s1.last  = last;
        n_s1.base  = r_base;
        n_s1.chan  = i_cfg.nhwc ? r_chan : '0;
        if (i_cfg.transpose) begin
            n_s1.dr = i_cfg.flip_y ? i_cfg.nh_m1 - r_col : r_col;
            n_s1.dc = i_cfg.flip_x ? i_cfg.nw_m1 - r_row : r_row;
        end else begin
            n_s1.dr = i_cfg.flip_y ? i_cfg.nh_m1 - r_row : r_row;
            n_s1.dc = i_cfg.flip_x ? i_cfg.nw_m1 - r_col : r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_batch <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_chan  <= '0;
            r_src   <= '0;
            r_base  <= '0;
        end else if (accept) begin
            r_batch <= n_batch;
            r_row   <= n_row;
            r_col   <= n_col;
            r_chan  <= n_chan;
            r_src   <= n_src;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

endmodule

// ----- hw/rtl/tdr_calc.sv -----
// tdr_calc: destination index arithmetic and result register
// depends on tdr_pkg
module tdr_calc import tdr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_s1_vld,
    output logic               o_s1_ready,
    input  t_item              i_s1,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [VALUE_W-1:0] o_moved_value,
    output logic [INDEX_W-1:0] o_dest_index,
    output logic               o_last
);

    logic               r_out_vld;
    logic [VALUE_W-1:0] r_value;
    logic [INDEX_W-1:0] r_dest, n_dest;
    logic               r_last;

    logic [SIDE_W+STRIDE_W-1:0] row_term;
    logic [SIDE_W+CSTR_W-1:0]   col_term;

    assign o_s1_ready    = !r_out_vld || i_out_ready;
    assign o_out_valid   = r_out_vld;
    assign o_moved_value = r_value;
    assign o_dest_index  = r_dest;
    assign o_last        = r_last;

    always_comb begin
        row_term = i_s1.dr * i_cfg.row_stride;
        col_term = i_s1.dc * i_cfg.col_stride;
        n_dest   = i_s1.base + INDEX_W'(row_term) + INDEX_W'(col_term)
                 + INDEX_W'(i_s1.chan);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_s1_ready) begin
            r_out_vld <= i_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_s1_vld) begin
            r_value <= i_s1.value;
            r_dest  <= n_dest;
            r_last  <= i_s1.last;
        end
    end

endmodule

// ----- hw/rtl/tensor_dihedral_remap_top.sv -----
// tensor_dihedral_remap_top: dihedral remap of a tensor element stream
// throughput: 1 request per cycle while the result output is not back-pressured
// two register stages: counters and flips into the input stage, index math into the result stage
// reset (synchronous, active low): config to defaults, counters to zero, both stages empty
// any valid config write restarts the tensor at element zero
// depends on tdr_pkg, tdr_cfg, tdr_seq, tdr_calc
module tensor_dihedral_remap_top import tdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_W-1:0]    o_moved_value,
    output logic [INDEX_W-1:0]    o_dest_index,
    output logic                  o_last
);

    t_cfg  cfg;
    logic  restart;
    logic  s1_vld;
    logic  s1_ready;
    t_item s1;

    tdr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    tdr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_restart  (restart),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .o_s1_vld   (s1_vld),
        .i_s1_ready (s1_ready),
        .o_s1       (s1)
    );

    tdr_calc u_calc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_s1_vld      (s1_vld),
        .o_s1_ready    (s1_ready),
        .i_s1          (s1),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_moved_value (o_moved_value),
        .o_dest_index  (o_dest_index),
        .o_last        (o_last)
    );

endmodule

// ----- hw/rtl/tdr_checker.sv -----
// tdr_checker: port level checks for tensor_dihedral_remap_top, with its bind
// depends on tdr_pkg
module tdr_checker import tdr_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [VALUE_W-1:0]    o_moved_value,
    input logic [INDEX_W-1:0]    o_dest_index,
    input logic                  o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_moved_value)
        && $stable(o_dest_index) && $stable(o_last))
        else $error("result changed while stalled");

    // empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    // a new result follows its request through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without request two cycles before");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind tensor_dihedral_remap_top tdr_checker u_chk (.*);

// ----- sim/tensor_dihedral_remap_top_test.sv -----
// tensor_dihedral_remap_top_test: self-checking bench for the dihedral remap block
// drives random requests under both-side stalls, predicts index and last flag per request
// depends on tdr_pkg and tensor_dihedral_remap_top
`timescale 1ns / 1ps

module tensor_dihedral_remap_top_test;
    import tdr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_remap_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [VALUE_W-1:0]    i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [VALUE_W-1:0]    o_moved_value;
    logic [INDEX_W-1:0]    o_dest_index;
    logic                  o_last;

    tensor_dihedral_remap_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_moved_value (o_moved_value),
        .o_dest_index  (o_dest_index),
        .o_last        (o_last)
    );

    // shadow config and element counters
    logic [BATCH_REG_W-1:0] cfg_batch;
    logic [SIDE_REG_W-1:0]  cfg_height;
    logic [SIDE_REG_W-1:0]  cfg_width;
    logic [CHAN_REG_W-1:0]  cfg_channels;
    logic                   cfg_nhwc;
    logic [SYM_W-1:0]       cfg_sym;
    logic                   cfg_reverse;
    int unsigned outer_cnt, row_cnt, col_cnt, chan_cnt;

    logic [VALUE_W-1:0] pending_words[$];
    t_remap_result      remap_expect[$];
    int  mismatch_count = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned max_size);
        if (raw == 0) return 1;
        if (raw > max_size) return max_size;
        return raw;
    endfunction

    function automatic int unsigned tensor_elements();
        return clamp_size(cfg_batch, MAX_BATCH) * clamp_size(cfg_height, MAX_SIDE) *
               clamp_size(cfg_width, MAX_SIDE) * clamp_size(cfg_channels, MAX_CHANNELS);
    endfunction

    function automatic void predict_remap(input logic [VALUE_W-1:0] word);
        int unsigned nb, nh, nw, nc, outer_lim, dr, dc, cc;
        bit tr, fx, fy, sw, is_last;
        longint unsigned dest;
        t_remap_result r;
        nb = clamp_size(cfg_batch, MAX_BATCH);
        nh = clamp_size(cfg_height, MAX_SIDE);
        nw = clamp_size(cfg_width, MAX_SIDE);
        nc = clamp_size(cfg_channels, MAX_CHANNELS);
        tr = cfg_sym[SYM_TRANSPOSE] && nh == nw;
        fx = cfg_sym[SYM_FLIP_COLS];
        fy = cfg_sym[SYM_FLIP_ROWS];
        if (tr && !cfg_reverse) begin
            sw = fx;
            fx = fy;
            fy = sw;
        end
        cc = cfg_nhwc ? chan_cnt : 0;
        if (tr) begin
            dr = fy ? nh - 1 - col_cnt : col_cnt;
            dc = fx ? nw - 1 - row_cnt : row_cnt;
        end else begin
            dr = fy ? nh - 1 - row_cnt : row_cnt;
            dc = fx ? nw - 1 - col_cnt : col_cnt;
        end
        outer_lim = cfg_nhwc ? nb : nb * nc;
        dest = (longint'(outer_cnt) * nh + dr) * nw + dc;
        if (cfg_nhwc) dest = dest * nc + cc;
        is_last = outer_cnt == outer_lim - 1 && row_cnt == nh - 1 && col_cnt == nw - 1 &&
                  (!cfg_nhwc || cc == nc - 1);
        r.value = word;
        r.index = dest[INDEX_W-1:0];
        r.last  = is_last;
        remap_expect.push_back(r);
        // advance in source order
        if (cfg_nhwc && chan_cnt + 1 < nc) begin
            chan_cnt++;
        end else begin
            chan_cnt = 0;
            if (col_cnt + 1 < nw) begin
                col_cnt++;
            end else begin
                col_cnt = 0;
                if (row_cnt + 1 < nh) begin
                    row_cnt++;
                end else begin
                    row_cnt = 0;
                    outer_cnt = (outer_cnt + 1 >= outer_lim) ? 0 : outer_cnt + 1;
                end
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_remap(i_value);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_value <= pending_words.pop_front();
                    if (send_idle_on && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_remap_result exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (remap_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: value %h index %h last %b",
                                 o_moved_value, o_dest_index, o_last);
                end else begin
                    exp_r = remap_expect.pop_front();
                    if (o_moved_value !== exp_r.value || o_dest_index !== exp_r.index ||
                        o_last !== exp_r.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp value %h index %h last %b, got %h %h %b",
                                     exp_r.value, exp_r.index, exp_r.last,
                                     o_moved_value, o_dest_index, o_last);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (recv_idle_on && $urandom_range(0, 7) == 0)
                    recv_stall <= $urandom_range(1, 16);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BATCH:    cfg_batch = data[BATCH_REG_W-1:0];
            CFG_HEIGHT:   cfg_height = data[SIDE_REG_W-1:0];
            CFG_WIDTH:    cfg_width = data[SIDE_REG_W-1:0];
            CFG_CHANNELS: cfg_channels = data[CHAN_REG_W-1:0];
            CFG_LAYOUT:   cfg_nhwc = data[0];
            CFG_SYMMETRY: cfg_sym = data[SYM_W-1:0];
            CFG_REVERSE:  cfg_reverse = data[0];
            default:      return;
        endcase
        outer_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
        chan_cnt = 0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || remap_expect.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_words(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0:       pending_words.push_back('0);
                1:       pending_words.push_back('1);
                default: pending_words.push_back($urandom);
            endcase
        end
    endtask

    initial begin
        int words_queued;
        int n;
        int side;
        cfg_batch = RST_BATCH;
        cfg_height = RST_HEIGHT;
        cfg_width = RST_WIDTH;
        cfg_channels = RST_CHANNELS;
        cfg_nhwc = 1'b0;
        cfg_sym = '0;
        cfg_reverse = 1'b0;
        outer_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
        chan_cnt = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        pending_words.push_back('0);
        pending_words.push_back('1);
        wait_idle();
        // unmapped index keeps the counters
        write_reg(CFG_UNUSED_IDX, '1);
        queue_words(1);
        wait_idle();
        // zero sizes act as one
        write_reg(CFG_BATCH, '0);
        write_reg(CFG_HEIGHT, '0);
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_CHANNELS, '0);
        queue_words(2);
        wait_idle();
        // oversize saturates
        write_reg(CFG_BATCH, '1);
        write_reg(CFG_HEIGHT, '1);
        write_reg(CFG_WIDTH, '1);
        write_reg(CFG_CHANNELS, '1);
        write_reg(CFG_LAYOUT, 1);
        write_reg(CFG_SYMMETRY, '1);
        write_reg(CFG_REVERSE, 1);
        queue_words(2);
        wait_idle();
        // transpose ignored on a non-square plane
        write_reg(CFG_BATCH, 1);
        write_reg(CFG_HEIGHT, 2);
        write_reg(CFG_WIDTH, 3);
        write_reg(CFG_CHANNELS, 1);
        write_reg(CFG_LAYOUT, 0);
        write_reg(CFG_SYMMETRY, (1 << SYM_TRANSPOSE) | (1 << SYM_FLIP_ROWS));
        write_reg(CFG_REVERSE, 0);
        queue_words(6);
        wait_idle();
        // square transpose in forward mode, channel innermost
        write_reg(CFG_WIDTH, 2);
        write_reg(CFG_CHANNELS, 2);
        write_reg(CFG_LAYOUT, 1);
        write_reg(CFG_SYMMETRY, '1);
        queue_words(8);
        words_queued = 21;

        while (words_queued < 1550) begin
            wait_idle();
            send_idle_on = words_queued < 1300 && $urandom_range(0, 3) != 0;
            recv_idle_on = words_queued < 1300 && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_UNUSED_IDX, $urandom_range(0, 511));
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    side = $urandom_range(1, 5);
                    write_reg(CFG_HEIGHT, side);
                    write_reg(CFG_WIDTH, $urandom_range(0, 1) ? side : $urandom_range(1, 5));
                end
                if ($urandom_range(0, 2) == 0) write_reg(CFG_CHANNELS, $urandom_range(1, 4));
                if ($urandom_range(0, 2) == 0) write_reg(CFG_BATCH, $urandom_range(1, 3));
                if ($urandom_range(0, 11) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       write_reg(CFG_BATCH, $urandom_range(0, 511));
                        1:       write_reg(CFG_HEIGHT, $urandom_range(0, 511));
                        2:       write_reg(CFG_WIDTH, $urandom_range(0, 511));
                        default: write_reg(CFG_CHANNELS, $urandom_range(0, 511));
                    endcase
                end
                if ($urandom_range(0, 1) == 1) write_reg(CFG_LAYOUT, $urandom_range(0, 511));
                write_reg(CFG_SYMMETRY, $urandom_range(0, 511));
                if ($urandom_range(0, 1) == 1) write_reg(CFG_REVERSE, $urandom_range(0, 511));
            end
            n = tensor_elements();
            if (n <= 40) n = n * $urandom_range(1, 2) + $urandom_range(0, 2);
            else n = $urandom_range(1, 24);
            queue_words(n);
            words_queued += n;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (remap_expect.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
